### design/assert_macros.svh
// assertion helpers shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define FBSP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define FBSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/fbsp_pkg.sv
package fbsp_pkg;

    // default size of one payload bank
    localparam int MAX_PAYLOAD_DEF = 32;
    // widths sized for the largest supported payload bank (64 entries)
    localparam int ADDR_W = 6;
    localparam int CNT_W = 7;
    localparam int CFG_IDX_W = 3;
    // two frames in flight: one being emitted, one being received
    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAD  = 3'd0,
        CFG_TAIL0 = 3'd1,
        CFG_TAIL1 = 3'd2,
        CFG_TAIL2 = 3'd3,
        CFG_TAIL3 = 3'd4
    } t_cfg_idx;

    // configuration write
    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] idx;
        logic [7:0]           data;
    } t_cfg_wr;

    // payload store write from the parser
    typedef struct packed {
        logic              we;
        logic              bank;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_mem_wr;

    // completed frame handed to the emitter
    typedef struct packed {
        logic [7:0]       src;
        logic [7:0]       dst;
        logic [7:0]       cmd;
        logic [7:0]       len;
        logic [CNT_W-1:0] count;
        logic             trunc;
        logic             bank;
    } t_desc;

endpackage

### design/fbsp_in_if.sv
interface fbsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

### design/fbsp_out_if.sv
interface fbsp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_id;
    logic [7:0] dest_id;
    logic [7:0] command;
    logic [7:0] length_field;
    logic       has_payload;
    logic [4:0] payload_index;
    logic [7:0] payload_byte;
    logic       truncated;
    logic       last;

    modport source (
        output valid, output source_id, output dest_id, output command,
        output length_field, output has_payload, output payload_index,
        output payload_byte, output truncated, output last,
        input ready
    );
    modport sink (
        input valid, input source_id, input dest_id, input command,
        input length_field, input has_payload, input payload_index,
        input payload_byte, input truncated, input last,
        output ready
    );
endinterface

### design/fbsp_front.sv
`include "assert_macros.svh"

module fbsp_front #(
    parameter int MAX_PAYLOAD = fbsp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fbsp_pkg::t_cfg_wr i_cfg,
    fbsp_in_if.sink           i_in,
    input  logic              i_full,
    output logic              o_push,
    output fbsp_pkg::t_desc   o_desc,
    output fbsp_pkg::t_mem_wr o_wr
);

    typedef enum logic [9:0] {
        PH_HEAD = 10'b00_0000_0001,
        PH_SRC  = 10'b00_0000_0010,
        PH_DST  = 10'b00_0000_0100,
        PH_LEN  = 10'b00_0000_1000,
        PH_CMD  = 10'b00_0001_0000,
        PH_DATA = 10'b00_0010_0000,
        PH_T0   = 10'b00_0100_0000,
        PH_T1   = 10'b00_1000_0000,
        PH_T2   = 10'b01_0000_0000,
        PH_T3   = 10'b10_0000_0000
    } t_phase;

    localparam logic [7:0] MAX_B = 8'(MAX_PAYLOAD);

    logic [7:0] r_head, r_tail0, r_tail1, r_tail2, r_tail3;
    t_phase     r_phase, n_phase;
    logic [7:0] r_src, n_src, r_dst, n_dst, r_len, n_len, r_cmd, n_cmd;
    logic [7:0] r_count, n_count;
    logic       r_bank, n_bank;
    logic       accept;
    logic [8:0] count_inc;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= 8'h00;
            r_tail0 <= 8'h00;
            r_tail1 <= 8'h00;
            r_tail2 <= 8'h00;
            r_tail3 <= 8'h00;
        end else if (i_cfg.we) begin
            case (i_cfg.idx)
                fbsp_pkg::CFG_HEAD:  r_head  <= i_cfg.data;
                fbsp_pkg::CFG_TAIL0: r_tail0 <= i_cfg.data;
                fbsp_pkg::CFG_TAIL1: r_tail1 <= i_cfg.data;
                fbsp_pkg::CFG_TAIL2: r_tail2 <= i_cfg.data;
                fbsp_pkg::CFG_TAIL3: r_tail3 <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // hold off while both payload banks are owned by queued frames
    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && i_in.ready;
    assign count_inc  = {1'b0, r_count} + 9'd1;

    // frame parser
    always_comb begin
        n_phase = r_phase;
        n_src   = r_src;
        n_dst   = r_dst;
        n_len   = r_len;
        n_cmd   = r_cmd;
        n_count = r_count;
        n_bank  = r_bank;
        o_push  = 1'b0;
        o_wr.we   = 1'b0;
        o_wr.bank = r_bank;
        o_wr.addr = r_count[fbsp_pkg::ADDR_W-1:0];
        o_wr.data = i_in.rx_byte;
        if (accept) begin
            case (r_phase)
                PH_HEAD: begin
                    if (i_in.rx_byte == r_head) n_phase = PH_SRC;
                end
                PH_SRC: begin
                    n_src   = i_in.rx_byte;
                    n_phase = PH_DST;
                end
                PH_DST: begin
                    n_dst   = i_in.rx_byte;
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    n_len   = i_in.rx_byte;
                    n_phase = (i_in.rx_byte == 8'h00) ? PH_HEAD : PH_CMD;
                end
                PH_CMD: begin
                    n_cmd   = i_in.rx_byte;
                    n_count = 8'h00;
                    n_phase = (r_len == 8'h01) ? PH_T0 : PH_DATA;
                end
                PH_DATA: begin
                    o_wr.we = (r_count < MAX_B);
                    n_count = count_inc[7:0];
                    if (count_inc + 9'd1 >= {1'b0, r_len}) n_phase = PH_T0;
                end
                PH_T0: n_phase = (i_in.rx_byte == r_tail0) ? PH_T1 : PH_HEAD;
                PH_T1: n_phase = (i_in.rx_byte == r_tail1) ? PH_T2 : PH_HEAD;
                PH_T2: n_phase = (i_in.rx_byte == r_tail2) ? PH_T3 : PH_HEAD;
                PH_T3: begin
                    n_phase = PH_HEAD;
                    if (i_in.rx_byte == r_tail3) begin
                        o_push = 1'b1;
                        n_bank = !r_bank;
                    end
                end
                default: n_phase = PH_HEAD;
            endcase
        end
    end

    // descriptor of the frame just closed
    always_comb begin
        o_desc.src   = r_src;
        o_desc.dst   = r_dst;
        o_desc.cmd   = r_cmd;
        o_desc.len   = r_len;
        o_desc.trunc = (r_count > MAX_B);
        o_desc.count = (r_count > MAX_B) ? fbsp_pkg::CNT_W'(MAX_PAYLOAD)
                                         : r_count[fbsp_pkg::CNT_W-1:0];
        o_desc.bank  = r_bank;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEAD;
            r_bank  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_bank  <= n_bank;
        end
    end

    // header fields
    always_ff @(posedge i_clk) begin
        r_src   <= n_src;
        r_dst   <= n_dst;
        r_len   <= n_len;
        r_cmd   <= n_cmd;
        r_count <= n_count;
    end

    `FBSP_ASSERT_IMPL(a_wr_in_data, i_clk, i_rst_n, o_wr.we, r_phase == PH_DATA && accept, "payload write outside data phase")
    `FBSP_ASSERT_IMPL(a_push_room, i_clk, i_rst_n, o_push, !i_full && r_phase == PH_T3, "frame pushed without queue room")

endmodule

### design/fbsp_desc_fifo.sv
`include "assert_macros.svh"

module fbsp_desc_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  fbsp_pkg::t_desc i_desc,
    input  logic            i_pop,
    output logic            o_valid,
    output logic            o_full,
    output fbsp_pkg::t_desc o_desc
);

    localparam int DEPTH = fbsp_pkg::QUEUE_DEPTH;
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    fbsp_pkg::t_desc r_ent [DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_desc  = r_ent[r_rd];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + PW'(1);
            if (i_pop) r_rd <= r_rd + PW'(1);
            if (i_push && !i_pop) r_count <= r_count + CW'(1);
            else if (!i_push && i_pop) r_count <= r_count - CW'(1);
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_ent[r_wr] <= i_desc;
    end

    `FBSP_ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, i_pop, o_valid, "pop from empty frame queue")
    `FBSP_ASSERT_NEXT(a_fill_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + CW'(1), "frame queue level lost a push")

endmodule

### design/fbsp_back.sv
`include "assert_macros.svh"

module fbsp_back #(
    parameter int MAX_PAYLOAD = fbsp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fbsp_pkg::t_mem_wr i_wr,
    input  logic              i_q_valid,
    input  fbsp_pkg::t_desc   i_q_desc,
    output logic              o_pop,
    fbsp_out_if.source        o_out
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int KW = $clog2(MAX_PAYLOAD + 1);
    localparam int CW = fbsp_pkg::CNT_W;

    // two payload banks, one per frame in flight
    logic [7:0]    r_mem [2][MAX_PAYLOAD];
    logic [KW-1:0] r_k;
    logic [CW-1:0] k_ext;
    logic          hdr_only, is_last, load;

    logic          r_o_valid;
    logic [7:0]    r_o_src, r_o_dst, r_o_cmd, r_o_len, r_o_byte;
    logic          r_o_has, r_o_trunc, r_o_last;
    logic [4:0]    r_o_idx;

    assign k_ext    = CW'(r_k);
    assign hdr_only = (i_q_desc.count == '0);
    assign is_last  = hdr_only || (k_ext + CW'(1) == i_q_desc.count);
    assign load     = i_q_valid && (!r_o_valid || o_out.ready);
    assign o_pop    = load && is_last;

    // payload store write
    always_ff @(posedge i_clk) begin
        if (i_wr.we) r_mem[i_wr.bank][i_wr.addr[AW-1:0]] <= i_wr.data;
    end

    // result counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_k       <= '0;
        end else begin
            if (load) r_o_valid <= 1'b1;
            else if (o_out.ready) r_o_valid <= 1'b0;
            if (load) r_k <= is_last ? '0 : r_k + KW'(1);
        end
    end

    // output register, payload byte read straight from the store
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o_src   <= i_q_desc.src;
            r_o_dst   <= i_q_desc.dst;
            r_o_cmd   <= i_q_desc.cmd;
            r_o_len   <= i_q_desc.len;
            r_o_has   <= !hdr_only;
            r_o_idx   <= hdr_only ? 5'd0 : k_ext[4:0];
            r_o_byte  <= hdr_only ? 8'h00 : r_mem[i_q_desc.bank][r_k[AW-1:0]];
            r_o_trunc <= !hdr_only && i_q_desc.trunc;
            r_o_last  <= is_last;
        end
    end

    assign o_out.valid         = r_o_valid;
    assign o_out.source_id     = r_o_src;
    assign o_out.dest_id       = r_o_dst;
    assign o_out.command       = r_o_cmd;
    assign o_out.length_field  = r_o_len;
    assign o_out.has_payload   = r_o_has;
    assign o_out.payload_index = r_o_idx;
    assign o_out.payload_byte  = r_o_byte;
    assign o_out.truncated     = r_o_trunc;
    assign o_out.last          = r_o_last;

    `FBSP_ASSERT_NEXT(a_pop_on_last, i_clk, i_rst_n, o_pop, r_o_valid && r_o_last && r_k == '0, "frame released before its last result")

endmodule

### design/framed_byte_stream_parser_core.sv
// Framed byte stream parser. One received byte is taken per cycle on i_in; the parser hunts
// for head, source, destination, length, command, data and four tail bytes, storing up to
// MAX_PAYLOAD data bytes in one of two payload banks. A completed frame goes into a two-entry
// frame queue and is emitted on o_out at one result per ready cycle: one result per stored
// data byte, or one header-only result. Input is taken every cycle except while two completed
// frames are still queued for output, since each owns one payload bank; the output rate is
// set by the single output register, loaded together with the one read port of the store. The
// user writes tail and head values via the i_cfg_* port while idle; the block does not check.
module framed_byte_stream_parser_core #(
    parameter int MAX_PAYLOAD = fbsp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fbsp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                     i_cfg_data,
    fbsp_in_if.sink                        i_in,
    fbsp_out_if.source                     o_out
);

    fbsp_pkg::t_cfg_wr cfg;
    fbsp_pkg::t_mem_wr mem_wr;
    fbsp_pkg::t_desc   push_desc, head_desc;
    logic              push, pop, q_valid, q_full;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    // byte parser
    fbsp_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .i_full  (q_full),
        .o_push  (push),
        .o_desc  (push_desc),
        .o_wr    (mem_wr)
    );

    // completed frames waiting for output
    fbsp_desc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_desc  (head_desc)
    );

    // result emitter with payload store
    fbsp_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (mem_wr),
        .i_q_valid (q_valid),
        .i_q_desc  (head_desc),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

### dv/framed_byte_stream_parser_core_test.sv
`timescale 1ns / 100ps

module framed_byte_stream_parser_core_test;

    localparam int MAX_STORED   = fbsp_pkg::MAX_PAYLOAD_DEF;
    localparam int IDLE_PCT     = 12;
    localparam int SETTLE_GAP   = 16;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_BEATS = 28;
    // how a sent frame ends: whole, or cut off after the destination byte
    localparam int ENDS_WHOLE   = -1;
    localparam int ENDS_EARLY   = -2;

    typedef enum logic [9:0] {
        PH_HUNT    = 10'b00_0000_0001,
        PH_SOURCE  = 10'b00_0000_0010,
        PH_DEST    = 10'b00_0000_0100,
        PH_LENGTH  = 10'b00_0000_1000,
        PH_COMMAND = 10'b00_0001_0000,
        PH_DATA    = 10'b00_0010_0000,
        PH_TAIL0   = 10'b00_0100_0000,
        PH_TAIL1   = 10'b00_1000_0000,
        PH_TAIL2   = 10'b01_0000_0000,
        PH_TAIL3   = 10'b10_0000_0000
    } t_parse_phase;

    typedef struct packed {
        logic [7:0] source_id;
        logic [7:0] dest_id;
        logic [7:0] command;
        logic [7:0] length_field;
        logic       has_payload;
        logic [4:0] payload_index;
        logic [7:0] payload_byte;
        logic       truncated;
        logic       last;
    } t_frame_result;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [fbsp_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [7:0]                     i_cfg_data;

    fbsp_in_if  u_in_if ();
    fbsp_out_if u_out_if ();

    framed_byte_stream_parser_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (u_in_if.sink),
        .o_out      (u_out_if.source)
    );

    // register copies and parser state of the predictor
    logic [7:0]      head_val;
    logic [7:0]      tail_val [4];
    t_parse_phase    parse_phase;
    logic [7:0]      src_byte;
    logic [7:0]      dst_byte;
    logic [7:0]      len_byte;
    logic [7:0]      cmd_byte;
    logic [7:0]      data_seen;
    logic [7:0]      data_buf [MAX_STORED];
    t_frame_result   pending_results [$];

    int mismatches;
    int stall_cycles;
    int rx_beats;
    bit steady_flow;

    always #4 i_clk = ~i_clk;

    // results sink, stalls now and then unless the flow is steady
    always @(posedge i_clk) begin
        u_out_if.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic note_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int unsigned seen,
                               input int unsigned want);
        if (seen != want) begin
            note_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, seen, want));
        end
    endtask

    // frame parser prediction, one received byte at a time
    function automatic void parse_rx_byte(input logic [7:0] b);
        int unsigned   kept;
        t_frame_result r;
        case (parse_phase)
            PH_HUNT: begin
                if (b == head_val) parse_phase = PH_SOURCE;
            end
            PH_SOURCE: begin
                src_byte    = b;
                parse_phase = PH_DEST;
            end
            PH_DEST: begin
                dst_byte    = b;
                parse_phase = PH_LENGTH;
            end
            PH_LENGTH: begin
                len_byte    = b;
                parse_phase = (b == 8'd0) ? PH_HUNT : PH_COMMAND;
            end
            PH_COMMAND: begin
                cmd_byte    = b;
                data_seen   = 8'd0;
                parse_phase = (len_byte == 8'd1) ? PH_TAIL0 : PH_DATA;
            end
            PH_DATA: begin
                if (data_seen < MAX_STORED) data_buf[data_seen] = b;
                data_seen = data_seen + 8'd1;
                if (int'(data_seen) + 1 >= int'(len_byte)) parse_phase = PH_TAIL0;
            end
            PH_TAIL0: parse_phase = (b == tail_val[0]) ? PH_TAIL1 : PH_HUNT;
            PH_TAIL1: parse_phase = (b == tail_val[1]) ? PH_TAIL2 : PH_HUNT;
            PH_TAIL2: parse_phase = (b == tail_val[2]) ? PH_TAIL3 : PH_HUNT;
            PH_TAIL3: begin
                parse_phase = PH_HUNT;
                if (b == tail_val[3]) begin
                    // completed frame: one result per kept data byte, or header only
                    kept           = (data_seen > MAX_STORED) ? MAX_STORED : data_seen;
                    r.source_id    = src_byte;
                    r.dest_id      = dst_byte;
                    r.command      = cmd_byte;
                    r.length_field = len_byte;
                    if (kept == 0) begin
                        r.has_payload   = 1'b0;
                        r.payload_index = 5'd0;
                        r.payload_byte  = 8'd0;
                        r.truncated     = 1'b0;
                        r.last          = 1'b1;
                        pending_results.push_back(r);
                    end else begin
                        for (int k = 0; k < kept; k++) begin
                            r.has_payload   = 1'b1;
                            r.payload_index = 5'(k);
                            r.payload_byte  = data_buf[k];
                            r.truncated     = (data_seen > MAX_STORED);
                            r.last          = (k + 1 == kept);
                            pending_results.push_back(r);
                        end
                    end
                end
            end
            default: parse_phase = PH_HUNT;
        endcase
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_frame_result seen;
        t_frame_result want;
        if (i_rst_n && u_out_if.valid && u_out_if.ready) begin
            seen = '{u_out_if.source_id, u_out_if.dest_id, u_out_if.command,
                     u_out_if.length_field, u_out_if.has_payload, u_out_if.payload_index,
                     u_out_if.payload_byte, u_out_if.truncated, u_out_if.last};
            if (pending_results.size() == 0) begin
                note_mismatch("result beat with nothing pending");
            end else begin
                want = pending_results.pop_front();
                check_field("source_id", seen.source_id, want.source_id);
                check_field("dest_id", seen.dest_id, want.dest_id);
                check_field("command", seen.command, want.command);
                check_field("length_field", seen.length_field, want.length_field);
                check_field("has_payload", seen.has_payload, want.has_payload);
                check_field("payload_index", seen.payload_index, want.payload_index);
                check_field("payload_byte", seen.payload_byte, want.payload_byte);
                check_field("truncated", seen.truncated, want.truncated);
                check_field("last", seen.last, want.last);
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (u_in_if.valid && u_in_if.ready) ||
            (u_out_if.valid && u_out_if.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("framed_byte_stream_parser_core_test failed");
            $finish;
        end
    end

    // one received byte, with random gaps before it
    task automatic send_byte(input logic [7:0] b);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            u_in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        u_in_if.valid   <= 1'b1;
        u_in_if.rx_byte <= b;
        do @(posedge i_clk); while (!u_in_if.ready);
        parse_rx_byte(b);
        rx_beats++;
    endtask

    // stop sending, wait for every pending result, then for the given gap
    task automatic wait_idle(input int gap);
        u_in_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (gap) @(posedge i_clk);
    endtask

    task automatic put_reg(input fbsp_pkg::t_cfg_idx idx, input logic [7:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        case (idx)
            fbsp_pkg::CFG_HEAD:  head_val    = v;
            fbsp_pkg::CFG_TAIL0: tail_val[0] = v;
            fbsp_pkg::CFG_TAIL1: tail_val[1] = v;
            fbsp_pkg::CFG_TAIL2: tail_val[2] = v;
            fbsp_pkg::CFG_TAIL3: tail_val[3] = v;
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [7:0] h, input logic [7:0] t0,
                                input logic [7:0] t1, input logic [7:0] t2,
                                input logic [7:0] t3);
        wait_idle(SETTLE_GAP);
        put_reg(fbsp_pkg::CFG_HEAD, h);
        put_reg(fbsp_pkg::CFG_TAIL0, t0);
        put_reg(fbsp_pkg::CFG_TAIL1, t1);
        put_reg(fbsp_pkg::CFG_TAIL2, t2);
        put_reg(fbsp_pkg::CFG_TAIL3, t3);
        i_cfg_we <= 1'b0;
    endtask

    // a frame with random header and data; ending selects a broken tail byte or a cut
    task automatic send_frame(input logic [7:0] len, input int ending);
        send_byte(head_val);
        send_byte(8'($urandom_range(255)));
        send_byte(8'($urandom_range(255)));
        if (ending == ENDS_EARLY) return;
        send_byte(len);
        if (len == 8'd0) return;
        send_byte(8'($urandom_range(255)));
        for (int i = 1; i < len; i++) send_byte(8'($urandom_range(255)));
        for (int t = 0; t < 4; t++) begin
            if (t == ending) begin
                send_byte(tail_val[t] ^ 8'($urandom_range(255, 1)));
                return;
            end
            send_byte(tail_val[t]);
        end
    endtask

    // header-only frame with all registers at their reset value
    task automatic test_reset_config();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'd1);
        send_byte(8'hFF);
        repeat (4) send_byte(8'h00);
    endtask

    // zero length drops the frame, the hunt resumes on the next byte
    task automatic test_zero_length();
        program_regs(8'hA5, 8'h01, 8'h80, 8'hFE, 8'h7F);
        send_byte(head_val);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'd0);
    endtask

    // broken first tail byte that equals the head value must not open a frame
    task automatic test_tail_mismatch();
        send_byte(head_val);
        send_byte(8'h5C);
        send_byte(8'hC5);
        send_byte(8'd1);
        send_byte(8'h3E);
        send_byte(head_val);
        send_frame(8'd1, ENDS_WHOLE);
    endtask

    // data bytes at both extremes
    task automatic test_data_extremes();
        send_byte(head_val);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'd3);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        for (int t = 0; t < 4; t++) send_byte(tail_val[t]);
    endtask

    // data that fills the store exactly, then just over and well past its size
    task automatic test_overflow();
        program_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_frame(8'd33, ENDS_WHOLE);
        send_frame(8'd34, ENDS_WHOLE);
        // hold the sender back until every result is out
        wait_idle(0);
        send_frame(8'd64, ENDS_WHOLE);
    endtask

    // one random piece of stream: mostly whole frames, some broken ones and noise
    task automatic send_random_frame();
        int         pick;
        int         lsel;
        logic [7:0] len;
        pick = $urandom_range(99);
        lsel = $urandom_range(99);
        if (lsel < 15) len = 8'd1;
        else if (lsel < 70) len = 8'($urandom_range(6, 2));
        else if (lsel < 85) len = 8'($urandom_range(31, 7));
        else len = 8'($urandom_range(36, 32));
        if (pick < 8) begin
            repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
        end else if (pick < 16) begin
            send_frame(8'd0, ENDS_WHOLE);
        end else if (pick < 28) begin
            send_frame(len, $urandom_range(3));
        end else if (pick < 33) begin
            send_frame(len, ENDS_EARLY);
        end else begin
            send_frame(len, ENDS_WHOLE);
        end
        if ($urandom_range(7) == 0) wait_idle(0);
    endtask

    task automatic test_random_stream(input bit no_gaps, input bit tails_like_head);
        int         start;
        logic [7:0] h;
        h = 8'($urandom_range(255));
        if (tails_like_head) begin
            program_regs(h, h, h, h, h);
        end else begin
            program_regs(h, 8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255)), 8'($urandom_range(255)));
        end
        steady_flow = no_gaps;
        start = rx_beats;
        while (rx_beats - start < RANDOM_BEATS) send_random_frame();
        steady_flow = 1'b0;
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= fbsp_pkg::CFG_HEAD;
        i_cfg_data      <= 8'h00;
        u_in_if.valid   <= 1'b0;
        u_in_if.rx_byte <= 8'h00;
        head_val    = 8'h00;
        tail_val    = '{8'h00, 8'h00, 8'h00, 8'h00};
        parse_phase = PH_HUNT;
        src_byte    = 8'h00;
        dst_byte    = 8'h00;
        len_byte    = 8'h00;
        cmd_byte    = 8'h00;
        data_seen   = 8'h00;
        mismatches   = 0;
        stall_cycles = 0;
        rx_beats     = 0;
        steady_flow  = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_config();
        test_zero_length();
        test_tail_mismatch();
        test_data_extremes();
        test_overflow();
        test_random_stream(1'b0, 1'b0);
        test_random_stream(1'b1, 1'b0);
        test_random_stream(1'b0, 1'b1);

        wait_idle(SETTLE_GAP * 4);
        if (mismatches == 0) begin
            $display("framed_byte_stream_parser_core_test passed");
        end else begin
            $display("framed_byte_stream_parser_core_test failed");
        end
        $finish;
    end

endmodule
